FILE: rtl/tisf_pkg.sv
// ----------------------------------------------------------------------------
// tisf_pkg
// telnet command filter: codes, parser phases and result type
// ----------------------------------------------------------------------------
package tisf_pkg;

  localparam logic [7:0] CodeIac     = 8'hFF;
  localparam logic [7:0] CodeWill    = 8'hFB;
  localparam logic [7:0] CodeGa      = 8'hF9;
  localparam logic [7:0] CodeSe      = 8'hF0;
  localparam logic [7:0] OptEcho     = 8'h01;
  localparam logic [7:0] CharNul     = 8'h00;
  localparam logic [7:0] CharNewline = 8'h0A;

  typedef enum logic [2:0] {
    PH_NORMAL  = 3'd0,
    PH_CMD     = 3'd1,
    PH_WILLOPT = 3'd2,
    PH_OPT     = 3'd3,
    PH_WAITNUL = 3'd4
  } phase_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] out_byte;
    logic       event_valid;
    logic       hide_input;
  } result_t;

endpackage

FILE: rtl/tisf_if.sv
// ----------------------------------------------------------------------------
// tisf_in_if / tisf_out_if
// valid/ready channels for received bytes and filtered results
// ----------------------------------------------------------------------------
interface tisf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tisf_out_if;
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] out_byte;
  logic       event_valid;
  logic       hide_input;

  modport source (output valid, output data_valid, output out_byte,
                  output event_valid, output hide_input, input ready);
  modport sink   (input valid, input data_valid, input out_byte,
                  input event_valid, input hide_input, output ready);
endinterface

FILE: rtl/tisf_decode.sv
// ----------------------------------------------------------------------------
// tisf_decode
// one parser step: byte, phase and echo flag in; next state and result out
// ----------------------------------------------------------------------------
module tisf_decode (
  input  logic             [7:0] byte_i,
  input  tisf_pkg::phase_t       phase_i,
  input  logic                   hidden_i,
  output tisf_pkg::phase_t       phase_o,
  output logic                   hidden_o,
  output tisf_pkg::result_t      res_o,
  output logic                   has_res_o
);

  logic fresh;
  logic show;

  always_comb begin
    phase_o  = tisf_pkg::PH_NORMAL;
    hidden_o = hidden_i;
    res_o    = '0;
    fresh    = 1'b0;
    show     = 1'b0;

    case (phase_i)
      tisf_pkg::PH_CMD: begin
        show = (byte_i != tisf_pkg::CodeWill);
        if (byte_i == tisf_pkg::CodeWill) begin
          phase_o = tisf_pkg::PH_WILLOPT;
        end else if (byte_i == tisf_pkg::CodeIac) begin
          res_o.data_valid = 1'b1;
          res_o.out_byte   = tisf_pkg::CodeIac;
        end else if (byte_i > tisf_pkg::CodeWill) begin
          phase_o = tisf_pkg::PH_OPT;
        end else if (byte_i == tisf_pkg::CodeGa) begin
          res_o.data_valid = 1'b1;
          res_o.out_byte   = tisf_pkg::CharNewline;
        end else if (byte_i < tisf_pkg::CodeSe) begin
          fresh = 1'b1;
        end
      end
      tisf_pkg::PH_WILLOPT: begin
        if (byte_i == tisf_pkg::OptEcho) begin
          phase_o = tisf_pkg::PH_WAITNUL;
        end else begin
          show = 1'b1;
        end
      end
      tisf_pkg::PH_OPT: begin
        phase_o = tisf_pkg::PH_NORMAL;
      end
      tisf_pkg::PH_WAITNUL: begin
        if (byte_i == tisf_pkg::CharNul) begin
          hidden_o          = 1'b1;
          res_o.event_valid = 1'b1;
          res_o.hide_input  = 1'b1;
        end else begin
          show  = 1'b1;
          fresh = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    // show event only when the flag was set
    if (show && hidden_i) begin
      hidden_o          = 1'b0;
      res_o.event_valid = 1'b1;
      res_o.hide_input  = 1'b0;
    end

    if (fresh) begin
      if (byte_i == tisf_pkg::CodeIac) begin
        phase_o = tisf_pkg::PH_CMD;
      end else if (byte_i != tisf_pkg::CharNul) begin
        res_o.data_valid = 1'b1;
        res_o.out_byte   = byte_i;
      end
    end

    has_res_o = res_o.data_valid | res_o.event_valid;
  end

endmodule

FILE: rtl/tisf_out_reg.sv
// ----------------------------------------------------------------------------
// tisf_out_reg
// result register towards the output channel
// ----------------------------------------------------------------------------
module tisf_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_i,
  input  tisf_pkg::result_t     res_i,
  output logic                  free_o,
  tisf_out_if.source            out_ch
);

  logic              valid_r;
  logic              valid_nxt;
  tisf_pkg::result_t res_r;

  assign free_o    = !valid_r || out_ch.ready;
  assign valid_nxt = load_i || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.data_valid  = res_r.data_valid;
  assign out_ch.out_byte    = res_r.out_byte;
  assign out_ch.event_valid = res_r.event_valid;
  assign out_ch.hide_input  = res_r.hide_input;

endmodule

FILE: rtl/telnet_iac_stream_filter.sv
// ----------------------------------------------------------------------------
// telnet_iac_stream_filter
// strips telnet commands from a received byte stream
// ----------------------------------------------------------------------------
//  channel   dir  payload                                          role
//  in_ch     in   in_byte[7:0]                                     raw received beat
//  out_ch    out  data_valid, out_byte[7:0], event_valid, hide_input  filtered result
//
//  one beat a cycle while out_ch does not stall: input register, one step of parse logic,
//  result register; beats with no result vanish
//  rst_n synchronous: parser back to normal data phase, input line visible
//  a stall on out_ch holds the result register and backs up into in_ch.ready
// ----------------------------------------------------------------------------
module telnet_iac_stream_filter (
  input  logic       clk,
  input  logic       rst_n,
  tisf_in_if.sink    in_ch,
  tisf_out_if.source out_ch
);

  logic              in_valid_r;
  logic              in_valid_nxt;
  logic [7:0]        in_byte_r;
  tisf_pkg::phase_t  phase_r;
  tisf_pkg::phase_t  phase_nxt;
  logic              hidden_r;
  logic              hidden_nxt;
  tisf_pkg::result_t res;
  logic              has_res;
  logic              out_free;
  logic              advance;
  logic              in_fire;

  tisf_decode u_decode (
    .byte_i    (in_byte_r),
    .phase_i   (phase_r),
    .hidden_i  (hidden_r),
    .phase_o   (phase_nxt),
    .hidden_o  (hidden_nxt),
    .res_o     (res),
    .has_res_o (has_res)
  );

  assign advance      = in_valid_r && (!has_res || out_free);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_valid_nxt = in_fire || (in_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      phase_r    <= tisf_pkg::PH_NORMAL;
      hidden_r   <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (advance) begin
        phase_r  <= phase_nxt;
        hidden_r <= hidden_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_ch.in_byte;
    end
  end

  tisf_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load_i (advance && has_res),
    .res_i  (res),
    .free_o (out_free),
    .out_ch (out_ch)
  );

endmodule

FILE: tb/tisf_filter_checker.sv
// ----------------------------------------------------------------------------
// tisf_filter_checker
// Watches both channels of the telnet command filter. Every accepted input beat
// steps a local copy of the parser (phase and echo-hidden flag); any result it
// produces is queued. Each accepted output beat is checked field by field
// against the oldest queued result. The failure count and the number of results
// still owed are handed up to the testbench top.
// ----------------------------------------------------------------------------
module tisf_filter_checker (
  input  logic clk,
  input  logic rst_n,
  tisf_in_if   in_mon,
  tisf_out_if  out_mon,
  output int   fail_count,
  output int   results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  tisf_pkg::phase_t  parse_phase = tisf_pkg::PH_NORMAL;
  bit                echo_hidden = 1'b0;
  tisf_pkg::result_t owed_q[$];
  int                errs = 0;

  function automatic void filter_byte(input logic [7:0] b, output bit has_res,
                                      output tisf_pkg::result_t res);
    tisf_pkg::phase_t ph;
    bit               show;
    bit               fresh;
    ph          = parse_phase;
    parse_phase = tisf_pkg::PH_NORMAL;
    show        = 1'b0;
    fresh       = 1'b0;
    res         = '0;
    case (ph)
      tisf_pkg::PH_CMD: begin
        show = (b != tisf_pkg::CodeWill);
        if (b == tisf_pkg::CodeWill) begin
          parse_phase = tisf_pkg::PH_WILLOPT;
        end else if (b == tisf_pkg::CodeIac) begin
          res.data_valid = 1'b1;
          res.out_byte   = tisf_pkg::CodeIac;
        end else if (b > tisf_pkg::CodeWill) begin
          parse_phase = tisf_pkg::PH_OPT;
        end else if (b == tisf_pkg::CodeGa) begin
          res.data_valid = 1'b1;
          res.out_byte   = tisf_pkg::CharNewline;
        end else if (b < tisf_pkg::CodeSe) begin
          fresh = 1'b1;
        end
      end
      tisf_pkg::PH_WILLOPT: begin
        if (b == tisf_pkg::OptEcho) parse_phase = tisf_pkg::PH_WAITNUL;
        else show = 1'b1;
      end
      tisf_pkg::PH_OPT: ;
      tisf_pkg::PH_WAITNUL: begin
        if (b == tisf_pkg::CharNul) begin
          echo_hidden     = 1'b1;
          res.event_valid = 1'b1;
          res.hide_input  = 1'b1;
        end else begin
          show  = 1'b1;
          fresh = 1'b1;
        end
      end
      default: fresh = 1'b1;
    endcase
    if (show && echo_hidden) begin
      echo_hidden     = 1'b0;
      res.event_valid = 1'b1;
      res.hide_input  = 1'b0;
    end
    if (fresh) begin
      if (b == tisf_pkg::CodeIac) begin
        parse_phase = tisf_pkg::PH_CMD;
      end else if (b != tisf_pkg::CharNul) begin
        res.data_valid = 1'b1;
        res.out_byte   = b;
      end
    end
    has_res = res.data_valid || res.event_valid;
  endfunction

  always @(posedge clk) begin : watch
    tisf_pkg::result_t want;
    tisf_pkg::result_t got;
    bit                has_res;
    if (!rst_n) begin
      parse_phase = tisf_pkg::PH_NORMAL;
      echo_hidden = 1'b0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.data_valid  = out_mon.data_valid;
        got.out_byte    = out_mon.out_byte;
        got.event_valid = out_mon.event_valid;
        got.hide_input  = out_mon.hide_input;
        if (owed_q.size() == 0) begin
          if (errs < 10)
            $display("%0t: unexpected result dv=%0b byte=%02h ev=%0b hide=%0b",
                     $realtime, got.data_valid, got.out_byte, got.event_valid,
                     got.hide_input);
          errs++;
        end else begin
          want = owed_q.pop_front();
          if (got.data_valid !== want.data_valid || got.out_byte !== want.out_byte ||
              got.event_valid !== want.event_valid ||
              got.hide_input !== want.hide_input) begin
            if (errs < 10)
              $display("%0t: mismatch exp dv=%0b byte=%02h ev=%0b hide=%0b, %s",
                       $realtime, want.data_valid, want.out_byte, want.event_valid,
                       want.hide_input,
                       $sformatf("got dv=%0b byte=%02h ev=%0b hide=%0b",
                                 got.data_valid, got.out_byte, got.event_valid,
                                 got.hide_input));
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        filter_byte(in_mon.in_byte, has_res, want);
        if (has_res) owed_q.push_back(want);
      end
    end
    fail_count   <= errs;
    results_owed <= owed_q.size();
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the telnet command filter. A short directed stream
// hits every command class and the echo hide/show cases, then random telnet
// sequences follow in bursts with random gaps. The receiver stalls on its own
// pattern, once holds off long enough to back the block up, and the sender
// twice pauses until every owed result has arrived.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CodeSb   = 8'hFA;
  localparam logic [7:0] CodeDo   = 8'hFD;
  localparam logic [7:0] CodeDont = 8'hFE;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   results_owed;
  bit   long_hold = 1'b0;

  logic [7:0] tx_bytes[$];

  tisf_in_if  in_ch ();
  tisf_out_if out_ch ();

  telnet_iac_stream_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tisf_filter_checker filter_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always #6 clk = ~clk;

  function automatic void queue_random_sequence();
    case ($urandom_range(0, 11))
      0, 1: tx_bytes.push_back(8'($urandom_range(1, 254)));
      2:    tx_bytes.push_back(tisf_pkg::CharNul);
      3:    tx_bytes.push_back(8'($urandom_range(0, 255)));
      4:    tx_bytes.push_back(tisf_pkg::CodeIac);
      5: begin
        tx_bytes.push_back(tisf_pkg::CodeIac);
        tx_bytes.push_back(8'($urandom_range(tisf_pkg::CodeSe, tisf_pkg::CodeWill - 1)));
      end
      6, 7: begin
        tx_bytes.push_back(tisf_pkg::CodeIac);
        tx_bytes.push_back(tisf_pkg::CodeWill);
        tx_bytes.push_back(tisf_pkg::OptEcho);
        tx_bytes.push_back(tisf_pkg::CharNul);
      end
      8: begin
        tx_bytes.push_back(tisf_pkg::CodeIac);
        tx_bytes.push_back(tisf_pkg::CodeWill);
        tx_bytes.push_back(tisf_pkg::OptEcho);
        tx_bytes.push_back(8'($urandom_range(0, 255)));
      end
      9: begin
        tx_bytes.push_back(tisf_pkg::CodeIac);
        tx_bytes.push_back(8'($urandom_range(tisf_pkg::CodeWill, tisf_pkg::CodeIac - 1)));
        tx_bytes.push_back(8'($urandom_range(0, 255)));
      end
      10: begin
        tx_bytes.push_back(tisf_pkg::CodeIac);
        tx_bytes.push_back(8'($urandom_range(0, tisf_pkg::CodeSe - 1)));
      end
      default: begin
        tx_bytes.push_back(tisf_pkg::CodeIac);
        tx_bytes.push_back(tisf_pkg::CodeWill);
        tx_bytes.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  task automatic send_queued();
    int burst;
    int gap;
    while (tx_bytes.size() > 0) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 16);
      while (burst > 0 && tx_bytes.size() > 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= tx_bytes.pop_front();
        do @(posedge clk); while (!in_ch.ready);
        burst--;
      end
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  initial begin
    #2400000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    int run;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(8, 48);
      repeat (run) begin
        if (long_hold) begin
          out_ch.ready <= 1'b0;
          repeat (120) @(posedge clk);
          long_hold = 1'b0;
        end
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_bytes = {8'h01, 8'hFE, tisf_pkg::CharNul,
                tisf_pkg::CodeIac, tisf_pkg::CodeIac,
                tisf_pkg::CodeIac, tisf_pkg::CodeGa,
                tisf_pkg::CodeIac, CodeSb,
                tisf_pkg::CodeIac, tisf_pkg::CodeWill,
                tisf_pkg::OptEcho, tisf_pkg::CharNul,
                tisf_pkg::CodeIac, tisf_pkg::CodeWill,
                tisf_pkg::OptEcho, tisf_pkg::CharNul,
                tisf_pkg::CodeIac, tisf_pkg::CodeWill, 8'h02,
                tisf_pkg::CodeIac, tisf_pkg::CodeWill,
                tisf_pkg::OptEcho, tisf_pkg::CharNul,
                tisf_pkg::CodeIac, tisf_pkg::CodeWill,
                tisf_pkg::OptEcho, tisf_pkg::CodeIac, 8'h41,
                tisf_pkg::CodeIac, CodeDo, tisf_pkg::CodeIac,
                tisf_pkg::CodeIac, tisf_pkg::CharNul,
                tisf_pkg::CodeIac, CodeDont, tisf_pkg::CharNul};
    send_queued();

    while (tx_bytes.size() < 400) queue_random_sequence();
    send_queued();
    wait_for_results();

    // long receiver hold-off while the sender keeps going
    long_hold = 1'b1;
    while (tx_bytes.size() < 420) queue_random_sequence();
    send_queued();
    wait_for_results();
    repeat (4) @(posedge clk);

    if (fail_count == 0 && results_owed == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
